// ===== rtl/mbc_pkg.sv =====
// Shared types, grid constants and neighbour lookup for the maze carver.
// No dependencies; used by mbc_ctrl, mbc_dpath and maze_backtracker_carver.
package mbc_pkg;

  localparam int GRID_W     = 16;
  localparam int GRID_H     = 16;
  localparam int MAX_CELLS  = 256;
  localparam int CELL_LIMIT = (GRID_W * GRID_H < MAX_CELLS) ? GRID_W * GRID_H : MAX_CELLS;
  localparam int COL_W      = $clog2(GRID_W);
  localparam int ROW_W      = 8;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    DIR_RIGHT  = 2'd0,
    DIR_BOTTOM = 2'd1,
    DIR_LEFT   = 2'd2,
    DIR_TOP    = 2'd3
  } dir_t;

  typedef struct packed {
    req_kind_t  req_type;
    logic [7:0] start_cell;
    logic [7:0] pick;
  } item_t;

  typedef struct packed {
    logic       carved;
    logic [7:0] from_cell;
    logic [7:0] to_cell;
    dir_t       wall_dir;
    logic       done_res;
  } result_t;

  // Stack frame: cell in bits 7:0, count in 10:8, direction k in 12+2k:11+2k
  typedef struct packed {
    dir_t [3:0] dirs;
    logic [2:0] count;
    logic [7:0] cell_idx;
  } frame_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] cell_idx;
  } nb_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic begin_maze;
    logic enter_start;
    logic enter_nb;
    logic scan;
    logic push;
    logic pop;
    logic take;
    logic res_none;
    logic res_done;
    logic emit;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic req_start;
    logic start_ok;
    logic depth_zero;
    logic depth_one;
    logic top_empty;
    logic nb_free;
    logic scan_last;
    logic out_free;
  } sts_t;

  typedef logic [MAX_CELLS-1:0][COL_W-1:0] col_tab_t;
  typedef logic [MAX_CELLS-1:0][ROW_W-1:0] row_tab_t;

  function automatic col_tab_t col_table();
    col_tab_t t;
    for (int i = 0; i < MAX_CELLS; i++) begin
      t[i] = COL_W'(i % GRID_W);
    end
    return t;
  endfunction

  function automatic row_tab_t row_table();
    row_tab_t t;
    for (int i = 0; i < MAX_CELLS; i++) begin
      t[i] = ROW_W'(i / GRID_W);
    end
    return t;
  endfunction

  localparam col_tab_t COL_OF = col_table();
  localparam row_tab_t ROW_OF = row_table();

  // Neighbour of a cell; ok is low when it lies off the grid or past cell 255
  function automatic nb_t neighbour(logic [7:0] cell_in, dir_t dir);
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [9:0]       n;
    nb_t              r;
    col = COL_OF[cell_in];
    row = ROW_OF[cell_in];
    unique case (dir)
      DIR_RIGHT: begin
        r.ok = (10'(col) + 10'd1) < 10'(GRID_W);
        n    = 10'(cell_in) + 10'd1;
      end
      DIR_BOTTOM: begin
        r.ok = (10'(row) + 10'd1) < 10'(GRID_H);
        n    = 10'(cell_in) + 10'(GRID_W);
      end
      DIR_LEFT: begin
        r.ok = (col != '0);
        n    = 10'(cell_in) - 10'd1;
      end
      DIR_TOP: begin
        r.ok = (row != '0);
        n    = 10'(cell_in) - 10'(GRID_W);
      end
      default: begin
        r.ok = 1'b0;
        n    = '0;
      end
    endcase
    if (n >= 10'(CELL_LIMIT)) begin
      r.ok = 1'b0;
    end
    r.cell_idx = n[7:0];
    return r;
  endfunction

endpackage

// ===== rtl/mbc_ctrl.sv =====
// Sequencing state machine for the maze carver.
// Depends on mbc_pkg; drives mbc_dpath through ctl_t and reads sts_t.
module mbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  mbc_pkg::sts_t sts,
  output mbc_pkg::ctl_t ctl
);
  import mbc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ENTER = 7'b0000010,
    S_PUSH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.capture = 1'b1;
          if (sts.req_start) begin
            ctl.begin_maze = 1'b1;
            ctl.res_none   = 1'b1;
            if (sts.start_ok) begin
              ctl.enter_start = 1'b1;
              state_next      = S_ENTER;
            end else begin
              ctl.res_done = 1'b1;
              state_next   = S_RESP;
            end
          end else if (sts.depth_zero) begin
            ctl.res_none = 1'b1;
            ctl.res_done = 1'b1;
            state_next   = S_RESP;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_ENTER: begin
        ctl.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        ctl.push   = 1'b1;
        state_next = S_RESP;
      end
      S_READ: begin
        // stack read data lands at the end of this cycle
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.top_empty) begin
          ctl.pop = 1'b1;
          if (sts.depth_one) begin
            ctl.res_none = 1'b1;
            ctl.res_done = 1'b1;
            state_next   = S_RESP;
          end else begin
            state_next = S_READ;
          end
        end else begin
          ctl.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.nb_free) begin
          ctl.enter_nb = 1'b1;
          state_next   = S_ENTER;
        end else begin
          ctl.res_none = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mbc_dpath.sv =====
// Datapath: visited flags, frame stack memory, frame builder and result register.
// Depends on mbc_pkg; commanded by mbc_ctrl.
module mbc_dpath (
  input  logic             clk,
  input  logic             rst,
  input  mbc_pkg::item_t   item_data,
  output logic             res_valid,
  input  logic             res_stall,
  output mbc_pkg::result_t res_data,
  input  mbc_pkg::ctl_t    ctl,
  output mbc_pkg::sts_t    sts
);
  import mbc_pkg::*;

  logic [MAX_CELLS-1:0] visited, visited_next;
  logic [8:0]           depth;
  logic [7:0]           top_addr;
  frame_t               stack_mem [MAX_CELLS];
  frame_t               rd_frame;
  frame_t               frame_acc;
  frame_t               frame_acc_next;
  frame_t               wb_frame;
  logic [7:0]           cell_cur;
  logic [7:0]           enter_idx;
  logic [1:0]           dir_ctr;
  logic [7:0]           pick_q;
  logic [7:0]           cell_sel;
  dir_t                 dir_sel;
  result_t              res;
  result_t              res_next;
  nb_t                  scan_nb;
  nb_t                  chk_nb;
  logic [2:0]           cnt;
  logic [10:0]          prod;
  logic [1:0]           idx;
  logic [1:0]           last;

  assign top_addr  = depth[7:0] - 8'd1;
  assign scan_nb   = neighbour(cell_cur, dir_t'(dir_ctr));
  assign chk_nb    = neighbour(cell_sel, dir_sel);
  assign enter_idx = ctl.enter_start ? item_data.start_cell : chk_nb.cell_idx;

  // Candidate selection on the top frame
  always_comb begin
    cnt  = (rd_frame.count > 3'd4) ? 3'd4 : rd_frame.count;
    prod = 11'(pick_q) * 11'(cnt);
    idx  = prod[9:8];
    last = 2'(cnt - 3'd1);
    wb_frame           = rd_frame;
    wb_frame.dirs[idx] = rd_frame.dirs[last];
    wb_frame.count     = cnt - 3'd1;
  end

  always_comb begin
    visited_next = visited;
    if (ctl.begin_maze) begin
      visited_next = '0;
    end
    if (ctl.enter_start) begin
      visited_next[item_data.start_cell] = 1'b1;
    end
    if (ctl.enter_nb) begin
      visited_next[chk_nb.cell_idx] = 1'b1;
    end
  end

  // Frame builder: one neighbour direction checked per scan cycle
  always_comb begin
    frame_acc_next = frame_acc;
    if (ctl.enter_start || ctl.enter_nb) begin
      frame_acc_next          = '0;
      frame_acc_next.cell_idx = enter_idx;
    end else if (ctl.scan && scan_nb.ok && !visited[scan_nb.cell_idx]) begin
      frame_acc_next.dirs[frame_acc.count[1:0]] = dir_t'(dir_ctr);
      frame_acc_next.count                      = frame_acc.count + 3'd1;
    end
  end

  always_comb begin
    res_next = res;
    if (ctl.res_none) begin
      res_next          = '0;
      res_next.done_res = ctl.res_done;
    end else if (ctl.enter_nb) begin
      res_next.carved    = 1'b1;
      res_next.from_cell = cell_sel;
      res_next.to_cell   = chk_nb.cell_idx;
      res_next.wall_dir  = dir_sel;
      res_next.done_res  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      depth   <= '0;
    end else begin
      visited <= visited_next;
      if (ctl.begin_maze) begin
        depth <= '0;
      end else if (ctl.push && !depth[8]) begin
        depth <= depth + 9'd1;
      end else if (ctl.pop) begin
        depth <= depth - 9'd1;
      end
    end
  end

  // Frame stack: one write port, one registered read of the top entry
  always_ff @(posedge clk) begin
    if (ctl.push && !depth[8]) begin
      stack_mem[depth[7:0]] <= frame_acc;
    end else if (ctl.take) begin
      stack_mem[top_addr] <= wb_frame;
    end
  end

  always_ff @(posedge clk) begin
    rd_frame <= stack_mem[top_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pick_q <= item_data.pick;
    end
    if (ctl.take) begin
      cell_sel <= rd_frame.cell_idx;
      dir_sel  <= rd_frame.dirs[idx];
    end
    if (ctl.enter_start || ctl.enter_nb) begin
      cell_cur <= enter_idx;
      dir_ctr  <= '0;
    end else if (ctl.scan) begin
      dir_ctr <= dir_ctr + 2'd1;
    end
    frame_acc <= frame_acc_next;
    res       <= res_next;
    if (ctl.emit) begin
      res_data <= res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.req_start  = (item_data.req_type == REQ_START);
    sts.start_ok   = (10'(item_data.start_cell) < 10'(CELL_LIMIT));
    sts.depth_zero = (depth == 9'd0);
    sts.depth_one  = (depth == 9'd1);
    sts.top_empty  = (rd_frame.count == 3'd0);
    sts.nb_free    = chk_nb.ok && !visited[chk_nb.cell_idx];
    sts.scan_last  = (dir_ctr == 2'd3);
    sts.out_free   = !(res_valid && res_stall);
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !depth[8])
    else $error("push on a full frame stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> depth != 9'd0)
    else $error("pop on an empty frame stack");

  a_take_live: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> (rd_frame.count != 3'd0 && depth != 9'd0))
    else $error("candidate taken from an empty frame");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !(res_valid && res_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/maze_backtracker_carver.sv =====
// Start: enters, scans and pushes the start cell; an off-grid start goes straight to
// the result. Step: pops empty frames (done if the stack empties or was empty), else
// takes and checks a candidate; if free, its cell is entered, scanned and pushed.
// One request in flight; the next is taken the cycle after the result is registered,
// even while that result is stalled. Pace: one visited lookup per cycle and the registered
// stack read. rst (sync) clears control, depth, visited flags; the stack is not reset.
module maze_backtracker_carver (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mbc_pkg::item_t   item_data,
  output logic             res_valid,
  input  logic             res_stall,
  output mbc_pkg::result_t res_data
);
  import mbc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  mbc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ===== tb/maze_backtracker_carver_tb.sv =====
// Self-checking testbench for maze_backtracker_carver: directed table, then random mazes.
// Depends on rtl/mbc_pkg.sv and rtl/maze_backtracker_carver.sv; has its own carver model.
module maze_backtracker_carver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbc_pkg::*;

  localparam int N_RANDOM       = 1800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int MAX_REPORTS    = 10;

  localparam result_t RES_IDLE_DONE = '{carved: 1'b0, from_cell: 8'd0, to_cell: 8'd0,
                                        wall_dir: DIR_RIGHT, done_res: 1'b1};
  localparam result_t RES_FRESH     = '{carved: 1'b0, from_cell: 8'd0, to_cell: 8'd0,
                                        wall_dir: DIR_RIGHT, done_res: 1'b0};

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item_data;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res_data;

  maze_backtracker_carver u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- carver model
  bit      seen_cell [MAX_CELLS];
  frame_t  trail [MAX_CELLS];
  int      trail_depth;

  result_t wall_expect_q[$];

  int n_sent;
  int n_starts;
  int n_steps;
  int n_carves;
  int n_completed;
  int n_checked;
  int n_fail;
  bit maze_live;

  function automatic bit step_to(input int cell_in, input dir_t d, output int nb);
    int col;
    int row;
    bit ok;
    col = cell_in % GRID_W;
    row = cell_in / GRID_W;
    ok  = 1'b0;
    nb  = 0;
    case (d)
      DIR_RIGHT: begin
        ok = (col + 1 < GRID_W);
        nb = cell_in + 1;
      end
      DIR_BOTTOM: begin
        ok = (row + 1 < GRID_H);
        nb = cell_in + GRID_W;
      end
      DIR_LEFT: begin
        ok = (col != 0);
        nb = cell_in - 1;
      end
      default: begin
        ok = (row != 0);
        nb = cell_in - GRID_W;
      end
    endcase
    // cells past 255 do not exist even on a wide grid
    if (nb >= CELL_LIMIT || nb < 0) ok = 1'b0;
    return ok;
  endfunction

  function automatic void visit_cell(input int cell_in);
    frame_t f;
    int     cnt;
    int     nb;
    seen_cell[cell_in] = 1'b1;
    f          = '0;
    f.cell_idx = cell_in[7:0];
    cnt        = 0;
    for (int d = 0; d < 4; d++) begin
      if (step_to(cell_in, dir_t'(d), nb) && !seen_cell[nb]) begin
        f.dirs[cnt] = dir_t'(d);
        cnt++;
      end
    end
    f.count = cnt[2:0];
    if (trail_depth < MAX_CELLS) begin
      trail[trail_depth] = f;
      trail_depth++;
    end
  endfunction

  function automatic result_t carve_outcome(input item_t it);
    result_t r;
    frame_t  f;
    int      cnt;
    int      idx;
    int      last;
    int      nb;
    dir_t    d;
    r = '0;
    if (it.req_type == REQ_START) begin
      foreach (seen_cell[i]) seen_cell[i] = 1'b0;
      trail_depth = 0;
      if (int'(it.start_cell) < CELL_LIMIT) visit_cell(int'(it.start_cell));
      r.done_res = (trail_depth == 0);
    end else begin
      while (trail_depth > 0 && trail[trail_depth-1].count == 3'd0) trail_depth--;
      if (trail_depth == 0) begin
        r.done_res = 1'b1;
      end else begin
        f   = trail[trail_depth-1];
        cnt = int'(f.count);
        if (cnt > 4) cnt = 4;
        idx  = (int'(it.pick) * cnt) >> 8;
        last = cnt - 1;
        d    = f.dirs[idx];
        // swap-remove: last entry fills the consumed slot
        f.dirs[idx] = f.dirs[last];
        f.count     = last[2:0];
        trail[trail_depth-1] = f;
        if (step_to(int'(f.cell_idx), d, nb) && !seen_cell[nb]) begin
          visit_cell(nb);
          r.carved    = 1'b1;
          r.from_cell = f.cell_idx;
          r.to_cell   = nb[7:0];
          r.wall_dir  = d;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- result side
  int stall_cycle;
  int stall_mode;
  int idle_cycles;

  task automatic take_result(input result_t got);
    result_t want;
    bit      bad;
    if (wall_expect_q.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("[%0t] unexpected result: carved=%0d from=%0d to=%0d dir=%0d done=%0d",
                 $realtime, got.carved, got.from_cell, got.to_cell, got.wall_dir,
                 got.done_res);
    end else begin
      want = wall_expect_q.pop_front();
      n_checked++;
      bad = (got.carved !== want.carved) || (got.from_cell !== want.from_cell) ||
            (got.to_cell !== want.to_cell) || (got.wall_dir !== want.wall_dir) ||
            (got.done_res !== want.done_res);
      if (bad) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display({"[%0t] mismatch: exp carved=%0d from=%0d to=%0d dir=%0d done=%0d,",
                    " got carved=%0d from=%0d to=%0d dir=%0d done=%0d"},
                   $realtime, want.carved, want.from_cell, want.to_cell, want.wall_dir,
                   want.done_res, got.carved, got.from_cell, got.to_cell, got.wall_dir,
                   got.done_res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall   <= 1'b0;
      stall_cycle = 0;
      stall_mode  = 0;
      idle_cycles = 0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= ($urandom_range(0, 3) == 0);
        2:       res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= ((stall_cycle % 8) < 3);
      endcase
      if (res_valid && !res_stall) begin
        take_result(res_data);
        idle_cycles = 0;
      end else if (item_valid && !item_stall) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- request side
  int burst_left;

  task automatic send_request(input item_t it, input bit pinned, input result_t pinned_res);
    result_t r;
    int      gap;
    item_data  <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    r = carve_outcome(it);
    if (pinned) r = pinned_res;
    wall_expect_q.push_back(r);
    n_sent++;
    if (it.req_type == REQ_START) begin
      n_starts++;
      maze_live = !r.done_res;
    end else begin
      n_steps++;
      if (r.carved) n_carves++;
      if (r.done_res && maze_live) begin
        n_completed++;
        maze_live = 1'b0;
      end
    end
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // sender holds off until every outstanding request has its result
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    while (wall_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] start_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'(0);
        1:       return 8'(GRID_W - 1);
        2:       return 8'((GRID_H - 1) * GRID_W);
        default: return 8'(CELL_LIMIT - 1);
      endcase
    end
    return 8'($urandom);
  endfunction

  typedef struct {
    item_t   it;
    bit      pinned;
    result_t res;
  } probe_row_t;

  probe_row_t probe_rows[$];

  function automatic void add_row(input req_kind_t k, input logic [7:0] s,
                                  input logic [7:0] p, input bit pinned, input result_t r);
    probe_row_t row;
    row.it.req_type   = k;
    row.it.start_cell = s;
    row.it.pick       = p;
    row.pinned        = pinned;
    row.res           = r;
    probe_rows.push_back(row);
  endfunction

  initial begin
    item_t it;
    int    steps;
    bit    full_run;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item_data   = '0;
    n_sent      = 0;
    n_starts    = 0;
    n_steps     = 0;
    n_carves    = 0;
    n_completed = 0;
    n_checked   = 0;
    n_fail      = 0;
    maze_live   = 1'b0;
    trail_depth = 0;
    foreach (seen_cell[i]) seen_cell[i] = 1'b0;
    burst_left  = $urandom_range(1, 16);

    // steps before any start report an empty stack
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b1, RES_IDLE_DONE);
    add_row(REQ_STEP,  8'hff, 8'hff, 1'b1, RES_IDLE_DONE);
    // top-left corner, then the pick extremes
    add_row(REQ_START, 8'h00, 8'h00, 1'b1, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'hff, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'hff, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h80, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    // bottom-right corner, restart mid-maze
    add_row(REQ_START, 8'(CELL_LIMIT - 1), 8'hff, 1'b1, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'hff, 8'hff, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h40, 1'b0, RES_FRESH);
    // top-right and bottom-left corners
    add_row(REQ_START, 8'(GRID_W - 1), 8'h00, 1'b1, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'hff, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_START, 8'((GRID_H - 1) * GRID_W), 8'h00, 1'b1, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h00, 1'b0, RES_FRESH);
    // interior cell with four open sides; start_cell ignored on steps
    add_row(REQ_START, 8'h88, 8'h00, 1'b1, RES_FRESH);
    add_row(REQ_STEP,  8'hff, 8'h00, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'h55, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'hff, 8'haa, 1'b0, RES_FRESH);
    add_row(REQ_STEP,  8'h00, 8'hff, 1'b0, RES_FRESH);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[i]) send_request(probe_rows[i].it, probe_rows[i].pinned,
                                         probe_rows[i].res);
    hold_until_drained();

    while (n_sent < N_RANDOM + probe_rows.size()) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: arbitrary requests of either kind
        repeat ($urandom_range(1, 6)) begin
          it.req_type   = req_kind_t'($urandom_range(0, 1));
          it.start_cell = 8'($urandom);
          it.pick       = 8'($urandom);
          send_request(it, 1'b0, RES_FRESH);
        end
      end else begin
        it.req_type   = REQ_START;
        it.start_cell = start_byte();
        it.pick       = 8'($urandom);
        send_request(it, 1'b0, RES_FRESH);
        full_run = ($urandom_range(0, 3) == 0);
        steps    = $urandom_range(5, 200);
        while (full_run ? maze_live : (steps > 0)) begin
          it.req_type   = REQ_STEP;
          it.start_cell = 8'($urandom);
          it.pick       = pick_byte();
          send_request(it, 1'b0, RES_FRESH);
          steps--;
        end
        // a few steps past completion
        if (full_run) begin
          repeat ($urandom_range(1, 3)) begin
            it.req_type   = REQ_STEP;
            it.start_cell = 8'($urandom);
            it.pick       = pick_byte();
            send_request(it, 1'b0, RES_FRESH);
          end
        end
      end
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    item_valid <= 1'b0;
    while (wall_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wall_expect_q.size() != 0) begin
      $display("%0d expected results never arrived", wall_expect_q.size());
      n_fail += wall_expect_q.size();
    end

    $display("Ran %0d maze starts and %0d carving steps: %0d walls removed, %0d mazes done",
             n_starts, n_steps, n_carves, n_completed);
    $display("Checked %0d results, %0d failures", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
